FILE: sv/sitoa_pkg.sv
`default_nettype none
package sitoa_pkg;

	localparam int unsigned DataW         = 32;
	localparam int unsigned NumDigits     = 10;
	localparam int unsigned BcdW          = 4 * NumDigits;
	localparam int unsigned StepsPerStage = 8;
	localparam int unsigned NumConvStages = DataW / StepsPerStage;
	localparam int unsigned CharW         = 7;
	localparam int unsigned OutDataW      = 8;

	localparam logic [CharW-1:0] AsciiZero  = 7'd48;
	localparam logic [CharW-1:0] AsciiMinus = 7'd45;

	typedef logic [3:0] dig_idx_t;
	typedef logic [NumDigits-1:0][3:0] bcd_t;

	// one item in flight through the shift-and-add-3 stages
	typedef struct packed {
		logic             neg;
		logic [BcdW-1:0]  bcd;
		logic [DataW-1:0] bin;
	} conv_t;

	// a group of double-dabble steps: adjust digits >= 5, then shift one bit in
	function automatic conv_t dabble_steps(conv_t c);
		conv_t                 r;
		logic [BcdW+DataW-1:0] sh;
		r = c;
		for (int s = 0; s < StepsPerStage; s++) begin
			for (int d = 0; d < NumDigits; d++) begin
				if (r.bcd[4*d +: 4] >= 4'd5)
					r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
			end
			sh    = {r.bcd, r.bin} << 1;
			r.bcd = sh[BcdW+DataW-1:DataW];
			r.bin = sh[DataW-1:0];
		end
		return r;
	endfunction

	// position of the highest nonzero digit, zero when every digit is zero
	function automatic dig_idx_t msd_index(logic [BcdW-1:0] bcd);
		dig_idx_t idx;
		idx = '0;
		for (int d = 0; d < NumDigits; d++) begin
			if (bcd[4*d +: 4] != 4'd0)
				idx = dig_idx_t'(d);
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

FILE: sv/sitoa_conv_stage.sv
`default_nettype none
module sitoa_conv_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire sitoa_pkg::conv_t in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output sitoa_pkg::conv_t     out_data
);
	import sitoa_pkg::*;

	logic  valid_q;
	conv_t data_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			data_q <= dabble_steps(in_data);
	end

endmodule
`default_nettype wire

FILE: sv/sitoa_serializer.sv
`default_nettype none
module sitoa_serializer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire sitoa_pkg::conv_t              in_data,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [sitoa_pkg::OutDataW-1:0]     m_tdata,
	output logic                               m_tlast
);
	import sitoa_pkg::*;

	logic             busy_q;
	logic             sign_q;
	dig_idx_t         pos_q;
	bcd_t             dig_q;
	logic             ovalid_q;
	logic [CharW-1:0] char_q;
	logic             olast_q;

	logic             out_free;
	logic             emit;
	logic             finish;
	logic [CharW-1:0] next_char;

	assign out_free  = !ovalid_q || m_tready;
	assign emit      = busy_q && out_free;
	assign finish    = emit && !sign_q && (pos_q == '0);
	assign in_ready  = !busy_q || finish;
	assign next_char = sign_q ? AsciiMinus : (AsciiZero + {3'b000, dig_q[pos_q]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (in_ready)
				busy_q <= in_valid;
			if (out_free)
				ovalid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sign_q <= in_data.neg;
			dig_q  <= in_data.bcd;
			pos_q  <= msd_index(in_data.bcd);
		end else if (emit) begin
			if (sign_q)
				sign_q <= 1'b0;
			else if (pos_q != '0)
				pos_q <= pos_q - dig_idx_t'(1);
		end
		if (emit) begin
			char_q  <= next_char;
			olast_q <= !sign_q && (pos_q == '0);
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {{(OutDataW-CharW){1'b0}}, char_q};
	assign m_tlast  = olast_q;

endmodule
`default_nettype wire

FILE: sv/signed_int_to_decimal_ascii_unit.sv
// channel   dir  tdata                   tuser  tlast
// s_        in   [31:0] value (signed)   -      -
// m_        out  [6:0] character, [7] 0  -      last character of the number
//
// one stage forms sign and magnitude, four stages each run eight shift-and-add-3
// steps, then the serializer sends one word per cycle: 1 to 11 words per number
// a new number enters the serializer on the cycle its previous last word moves
// into the output register, so throughput is set by the text length
// arst_n clears all valid and busy flags; m_tready low stalls the serializer and
// the stages behind it fill up and hold their words
`default_nettype none
module signed_int_to_decimal_ascii_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [sitoa_pkg::DataW-1:0] s_tdata,   // [31:0] value
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [sitoa_pkg::OutDataW-1:0] m_tdata,     // [6:0] character
	output logic                           m_tlast
);
	import sitoa_pkg::*;

	logic  valid_s1;
	conv_t data_s1;

	logic  [NumConvStages:0] cv_valid;
	logic  [NumConvStages:0] cv_ready;
	conv_t                   cv_data [NumConvStages+1];

	assign s_tready = !valid_s1 || cv_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// magnitude as unsigned, so the most negative value needs no special case
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1.neg <= s_tdata[DataW-1];
			data_s1.bcd <= '0;
			data_s1.bin <= s_tdata[DataW-1] ? (~s_tdata + DataW'(1)) : s_tdata;
		end
	end

	assign cv_valid[0] = valid_s1;
	assign cv_data[0]  = data_s1;

	for (genvar g = 0; g < NumConvStages; g++) begin : g_conv
		sitoa_conv_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cv_valid[g]),
			.in_ready  (cv_ready[g]),
			.in_data   (cv_data[g]),
			.out_valid (cv_valid[g+1]),
			.out_ready (cv_ready[g+1]),
			.out_data  (cv_data[g+1])
		);
	end

	sitoa_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cv_valid[NumConvStages]),
		.in_ready (cv_ready[NumConvStages]),
		.in_data  (cv_data[NumConvStages]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire
